>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes, clocked on clk_i and idle during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// screen geometry, operation codes, sequencer states and address helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = $clog2(CELLS);

  localparam logic [BYTE_W-1:0] BLANK_CHAR    = 8'h20;
  localparam logic [BYTE_W-1:0] RESET_COLOR   = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL    = {RESET_COLOR, BLANK_CHAR};

  localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);

  typedef enum logic [2:0] {
    KIND_PUT_CHAR  = 3'd0,
    KIND_PUT_AT    = 3'd1,
    KIND_NEWLINE   = 3'd2,
    KIND_BACKSPACE = 3'd3,
    KIND_CLEAR_SCR = 3'd4,
    KIND_CLEAR_LN  = 3'd5,
    KIND_READ      = 3'd6,
    KIND_NOP       = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_READ,
    ST_RESP
  } state_e;

  function automatic logic col_ok(input logic [COL_W-1:0] col);
    col_ok = ({1'b0, col} < (COL_W + 1)'(COLUMNS));
  endfunction

  function automatic logic row_ok(input logic [ROW_W-1:0] row);
    row_ok = ({1'b0, row} < (ROW_W + 1)'(ROWS));
  endfunction

  // row-major cell index, only meaningful for on-screen coordinates
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  endfunction

endpackage

>>> design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/text_console_cursor_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer_unit
// 80x25 text screen store with a cursor, driven one command at a time
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// on the result ports for exactly one cycle with done_o high and cannot be
// held off, so capture it on that cycle. Cursor writes, put-at, newline,
// backspace, the unused code and anything off screen go from execute
// straight to response; an on-screen read passes through the read state
// (registered read port of the screen ram) and a clear through the sweep
// state: the one sweep counter writes a single cell per cycle through the
// single ram write port. After reset busy stays high while the same counter
// fills the screen with spaces in colour 0x0F. The colour register
// is written through its own valid/ready channel, which is always ready.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module text_console_cursor_writer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 kind_i,
  input  logic [tcw_pkg::BYTE_W-1:0] char_code_i,
  input  logic [tcw_pkg::BYTE_W-1:0] attr_i,
  input  logic [tcw_pkg::COL_W-1:0]  col_i,
  input  logic [tcw_pkg::ROW_W-1:0]  line_num_i,
  // result channel
  output logic                       done_o,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col_o,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::CELL_W-1:0] cell_data_o,
  output logic                       out_of_range_o,
  // colour register write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcw_pkg::BYTE_W-1:0] cfg_data_i
);

  import tcw_pkg::*;

  // sequencer and cursor
  state_e             state_q, state_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [BYTE_W-1:0]  color_q;

  // latched command
  kind_e              kind_q;
  logic [BYTE_W-1:0]  char_q;
  logic [BYTE_W-1:0]  attr_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   line_q;

  // result registers
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic               oor_q, oor_d;

  // sweep counter, shared by the reset fill, clear screen and clear line
  logic [ADDR_W-1:0]  sweep_addr_q, sweep_addr_d;
  logic [ADDR_W-1:0]  sweep_last_q, sweep_last_d;

  // screen ram ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  logic               accept;
  logic [COL_W-1:0]   bs_col;
  logic [ROW_W-1:0]   bs_row;
  logic [ADDR_W-1:0]  line_base;

  assign accept      = start && !busy;
  assign busy        = !(state_q == ST_IDLE || state_q == ST_RESP);
  assign cfg_ready_o = 1'b1;

  // backspace target: one cell back, wrapping to the end of the row above
  assign bs_col    = (cur_col_q == '0) ? LAST_COL : cur_col_q - COL_W'(1);
  assign bs_row    = (cur_col_q == '0) ? cur_row_q - ROW_W'(1) : cur_row_q;
  assign line_base = cell_addr(line_q, '0);
  assign ram_raddr = cell_addr(line_q, col_q);

  always_comb begin
    state_d      = state_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    cell_d       = cell_q;
    oor_d        = oor_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    ram_we       = 1'b0;
    ram_waddr    = cell_addr(cur_row_q, cur_col_q);
    ram_wdata    = {color_q, char_q};

    case (state_q)
      // power-up fill with the fixed reset cell
      ST_INIT: begin
        ram_we       = 1'b1;
        ram_waddr    = sweep_addr_q;
        ram_wdata    = RESET_CELL;
        sweep_addr_d = sweep_addr_q + ADDR_W'(1);
        if (sweep_addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE, ST_RESP: begin
        if (accept) begin
          state_d = ST_EXEC;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_EXEC: begin
        cell_d  = '0;
        oor_d   = 1'b0;
        state_d = ST_RESP;
        case (kind_q)
          KIND_PUT_CHAR: begin
            ram_we = 1'b1;
            if (cur_col_q == LAST_COL) begin
              cur_col_d = '0;
              cur_row_d = (cur_row_q == LAST_ROW) ? '0 : cur_row_q + ROW_W'(1);
            end else begin
              cur_col_d = cur_col_q + COL_W'(1);
            end
          end
          KIND_PUT_AT: begin
            ram_waddr = ram_raddr;
            ram_wdata = {attr_q, char_q};
            if (col_ok(col_q) && row_ok(line_q)) begin
              ram_we = 1'b1;
            end else begin
              oor_d = 1'b1;
            end
          end
          KIND_NEWLINE: begin
            cur_col_d = '0;
            cur_row_d = (cur_row_q == LAST_ROW) ? '0 : cur_row_q + ROW_W'(1);
          end
          KIND_BACKSPACE: begin
            // nothing happens at the home position
            if (cur_col_q != '0 || cur_row_q != '0) begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(bs_row, bs_col);
              ram_wdata = {color_q, BLANK_CHAR};
              cur_col_d = bs_col;
              cur_row_d = bs_row;
            end
          end
          KIND_CLEAR_SCR: begin
            cur_col_d    = '0;
            cur_row_d    = '0;
            sweep_addr_d = '0;
            sweep_last_d = LAST_ADDR;
            state_d      = ST_SWEEP;
          end
          KIND_CLEAR_LN: begin
            if (row_ok(line_q)) begin
              sweep_addr_d = line_base;
              sweep_last_d = line_base + ADDR_W'(COLUMNS - 1);
              state_d      = ST_SWEEP;
            end else begin
              oor_d = 1'b1;
            end
          end
          KIND_READ: begin
            // read port already addressed from the latched coordinates
            if (col_ok(col_q) && row_ok(line_q)) begin
              state_d = ST_READ;
            end else begin
              oor_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // one blank cell in the current colour per cycle
      ST_SWEEP: begin
        ram_we       = 1'b1;
        ram_waddr    = sweep_addr_q;
        ram_wdata    = {color_q, BLANK_CHAR};
        sweep_addr_d = sweep_addr_q + ADDR_W'(1);
        if (sweep_addr_q == sweep_last_q) begin
          state_d = ST_RESP;
        end
      end

      ST_READ: begin
        cell_d  = ram_rdata;
        state_d = ST_RESP;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      color_q      <= RESET_COLOR;
      cell_q       <= '0;
      oor_q        <= 1'b0;
      sweep_addr_q <= '0;
      sweep_last_q <= LAST_ADDR;
    end else begin
      state_q      <= state_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      cell_q       <= cell_d;
      oor_q        <= oor_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
    end
  end

  // command fields, captured on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      char_q <= char_code_i;
      attr_q <= attr_i;
      col_q  <= col_i;
      line_q <= line_num_i;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o         = (state_q == ST_RESP);
  assign cursor_col_o   = cur_col_q;
  assign cursor_row_o   = cur_row_q;
  assign cell_data_o    = cell_q;
  assign out_of_range_o = oor_q;

  `ASSERT_ALWAYS(a_cursor_on_screen, col_ok(cur_col_q) && row_ok(cur_row_q), "cursor off screen")
  `ASSERT_NEXT(a_busy_after_transfer, accept, busy && !done_o, "command not held busy")
  `ASSERT_IMPLIES(a_oor_no_data, done_o && oor_q, cell_q == '0, "data with out-of-range flag")
  `ASSERT_IMPLIES(a_sweep_bound, state_q == ST_SWEEP, sweep_addr_q <= sweep_last_q, "sweep overrun")

endmodule

>>> tb/text_console_cursor_writer_unit_test.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer_unit_test
// self-checking bench for the text console: a shadow screen and cursor
// predict every status report, and colour settings change between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_writer_unit_test;

  import tcw_pkg::*;

  // generous ceiling on the run
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // cycles allowed after the last report before the verdict
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 480;
  localparam int unsigned SCREEN_CLEARS_PER_PHASE = 3;

  typedef struct {
    kind_e             kind;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  // what the block reports after each command
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cell_data;
    logic              oor;
  } console_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [2:0]          kind_i;
  logic [BYTE_W-1:0]   char_code_i;
  logic [BYTE_W-1:0]   attr_i;
  logic [COL_W-1:0]    col_i;
  logic [ROW_W-1:0]    line_num_i;
  logic                done_o;
  logic [COL_W-1:0]    cursor_col_o;
  logic [ROW_W-1:0]    cursor_row_o;
  logic [CELL_W-1:0]   cell_data_o;
  logic                out_of_range_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [BYTE_W-1:0]   cfg_data_i;

  // shadow copy of the screen, cursor and colour register
  logic [CELL_W-1:0]   shadow_cells [CELLS];
  logic [COL_W-1:0]    shadow_col;
  logic [ROW_W-1:0]    shadow_row;
  logic [BYTE_W-1:0]   shadow_colour;

  console_status_t     status_reports_q [$];
  int unsigned         error_count = 0;
  int unsigned         cycle_count;
  bit                  gaps_on;

  text_console_cursor_writer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .attr_i         (attr_i),
    .col_i          (col_i),
    .line_num_i     (line_num_i),
    .done_o         (done_o),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .cell_data_o    (cell_data_o),
    .out_of_range_o (out_of_range_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow model
  // ---------------------------------------------------------------------------

  // row after a newline or a wrap off the last column, wrapping past the bottom
  function automatic logic [ROW_W-1:0] row_below(input logic [ROW_W-1:0] r);
    row_below = (int'(r) == ROWS - 1) ? '0 : r + 1'b1;
  endfunction

  function automatic void blank_row(input int unsigned r);
    for (int unsigned x = 0; x < COLUMNS; x++) begin
      shadow_cells[r * COLUMNS + x] = {shadow_colour, BLANK_CHAR};
    end
  endfunction

  // applies one command to the shadow state and returns the status it causes
  function automatic console_status_t compute_console_status(input console_cmd_t c);
    console_status_t s;
    bit              on_screen;
    s = '0;
    on_screen = (int'(c.col) < COLUMNS) && (int'(c.row) < ROWS);
    case (c.kind)
      KIND_PUT_CHAR: begin
        shadow_cells[int'(shadow_row) * COLUMNS + int'(shadow_col)] = {shadow_colour, c.ch};
        if (int'(shadow_col) == COLUMNS - 1) begin
          shadow_col = '0;
          shadow_row = row_below(shadow_row);
        end else begin
          shadow_col = shadow_col + 1'b1;
        end
      end
      KIND_PUT_AT: begin
        if (on_screen) begin
          shadow_cells[int'(c.row) * COLUMNS + int'(c.col)] = {c.attr, c.ch};
        end else begin
          s.oor = 1'b1;
        end
      end
      KIND_NEWLINE: begin
        shadow_col = '0;
        shadow_row = row_below(shadow_row);
      end
      KIND_BACKSPACE: begin
        // nothing moves at home; from column 0 it steps to the end of the row above
        if (shadow_col != '0 || shadow_row != '0) begin
          if (shadow_col == '0) begin
            shadow_col = COL_W'(COLUMNS - 1);
            shadow_row = shadow_row - 1'b1;
          end else begin
            shadow_col = shadow_col - 1'b1;
          end
          shadow_cells[int'(shadow_row) * COLUMNS + int'(shadow_col)] =
            {shadow_colour, BLANK_CHAR};
        end
      end
      KIND_CLEAR_SCR: begin
        for (int unsigned y = 0; y < ROWS; y++) blank_row(y);
        shadow_col = '0;
        shadow_row = '0;
      end
      KIND_CLEAR_LN: begin
        // only the row is checked here
        if (int'(c.row) < ROWS) begin
          blank_row(32'(c.row));
        end else begin
          s.oor = 1'b1;
        end
      end
      KIND_READ: begin
        if (on_screen) begin
          s.cell_data = shadow_cells[int'(c.row) * COLUMNS + int'(c.col)];
        end else begin
          s.oor = 1'b1;
        end
      end
      default: ;
    endcase
    s.col = shadow_col;
    s.row = shadow_row;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // drives one command from a falling edge and holds it until the block takes it;
  // start stays high on return so back-to-back commands need no toggle
  task automatic issue_cmd(input console_cmd_t c);
    if (gaps_on && $urandom_range(99) < 25) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start       = 1'b1;
    kind_i      = c.kind;
    char_code_i = c.ch;
    attr_i      = c.attr;
    col_i       = c.col;
    line_num_i  = c.row;
    do @(posedge clk_i); while (busy);
    // transfer happened at this edge
    status_reports_q.push_back(compute_console_status(c));
    @(negedge clk_i);
  endtask

  function automatic console_cmd_t make_cmd(input kind_e k, input int unsigned ch,
                                            input int unsigned attr, input int unsigned col,
                                            input int unsigned row);
    console_cmd_t c;
    c.kind = k;
    c.ch   = BYTE_W'(ch);
    c.attr = BYTE_W'(attr);
    c.col  = COL_W'(col);
    c.row  = ROW_W'(row);
    return c;
  endfunction

  // lets every outstanding report arrive and the block fall idle
  task automatic wait_until_quiet();
    start = 1'b0;
    do @(posedge clk_i); while (status_reports_q.size() != 0 || busy);
    @(negedge clk_i);
  endtask

  // register write, only issued with the block idle
  task automatic write_default_colour(input logic [BYTE_W-1:0] colour);
    cfg_valid_i = 1'b1;
    cfg_data_i  = colour;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_colour = colour;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = BYTE_W'($urandom_range(255));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // the power-up fill: spaces in white on black at two corners and the centre, cursor home
  task automatic test_reset_contents();
    issue_cmd(make_cmd(KIND_READ, 0, 0, 0, 0));
    issue_cmd(make_cmd(KIND_READ, 0, 0, COLUMNS - 1, ROWS - 1));
    issue_cmd(make_cmd(KIND_READ, 0, 0, COLUMNS / 2, ROWS / 2));
    issue_cmd(make_cmd(KIND_NOP, 8'hFF, 8'hFF, 127, 31));
    wait_until_quiet();
  endtask

  // field extremes, off-screen coordinates, backspace corners and both clears
  task automatic test_directed_ops();
    write_default_colour(8'h5A);
    issue_cmd(make_cmd(KIND_PUT_CHAR, 8'h00, 0, 0, 0));
    issue_cmd(make_cmd(KIND_PUT_CHAR, 8'hFF, 0, 0, 0));
    issue_cmd(make_cmd(KIND_BACKSPACE, 0, 0, 0, 0));
    issue_cmd(make_cmd(KIND_READ, 0, 0, 1, 0));
    issue_cmd(make_cmd(KIND_PUT_AT, 8'hFF, 8'h00, 0, 0));
    issue_cmd(make_cmd(KIND_PUT_AT, 8'h00, 8'hFF, COLUMNS - 1, ROWS - 1));
    issue_cmd(make_cmd(KIND_READ, 0, 0, COLUMNS - 1, ROWS - 1));
    // column just past the edge, all ones, then row just past the edge
    issue_cmd(make_cmd(KIND_PUT_AT, 8'h41, 8'h07, COLUMNS, 0));
    issue_cmd(make_cmd(KIND_PUT_AT, 8'h41, 8'h07, 127, 31));
    issue_cmd(make_cmd(KIND_PUT_AT, 8'h41, 8'h07, 0, ROWS));
    issue_cmd(make_cmd(KIND_READ, 0, 0, COLUMNS, 0));
    issue_cmd(make_cmd(KIND_READ, 0, 0, 0, 31));
    issue_cmd(make_cmd(KIND_READ, 0, 0, 127, 31));
    // backspace from the start of a line lands on the last column above
    issue_cmd(make_cmd(KIND_NEWLINE, 0, 0, 0, 0));
    issue_cmd(make_cmd(KIND_BACKSPACE, 0, 0, 0, 0));
    issue_cmd(make_cmd(KIND_READ, 0, 0, COLUMNS - 1, 0));
    issue_cmd(make_cmd(KIND_CLEAR_LN, 0, 0, 0, ROWS - 1));
    issue_cmd(make_cmd(KIND_READ, 0, 0, COLUMNS - 1, ROWS - 1));
    issue_cmd(make_cmd(KIND_CLEAR_LN, 0, 0, 127, 31));
    issue_cmd(make_cmd(KIND_NOP, 0, 0, 0, 0));
    issue_cmd(make_cmd(KIND_CLEAR_SCR, 0, 0, 0, 0));
    // backspace at home does nothing
    issue_cmd(make_cmd(KIND_BACKSPACE, 0, 0, 0, 0));
    issue_cmd(make_cmd(KIND_READ, 0, 0, 0, 0));
    wait_until_quiet();
  endtask

  // mostly typing with bursts long enough to wrap lines, reads that land on
  // the screen, and a share of off-screen coordinates and unused codes
  task automatic run_console_traffic(input int unsigned count);
    int unsigned  sent;
    int unsigned  clears_left;
    int unsigned  pick;
    int unsigned  burst;
    console_cmd_t c;
    sent        = 0;
    clears_left = SCREEN_CLEARS_PER_PHASE;
    while (sent < count) begin
      c = make_cmd(KIND_PUT_CHAR, $urandom_range(255), $urandom_range(255),
                   $urandom_range(127), $urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 2) begin
        // half a line to a line and a half of text without a break
        burst = $urandom_range(40, 120);
        for (int unsigned i = 0; i < burst; i++) begin
          issue_cmd(make_cmd(KIND_PUT_CHAR, $urandom_range(255), $urandom_range(255),
                             $urandom_range(127), $urandom_range(31)));
        end
        sent += burst;
      end else begin
        if (pick < 40) begin
          c.kind = KIND_PUT_CHAR;
        end else if (pick < 52) begin
          c.kind = KIND_PUT_AT;
          if ($urandom_range(99) < 80) begin
            c.col = COL_W'($urandom_range(COLUMNS - 1));
            c.row = ROW_W'($urandom_range(ROWS - 1));
          end
        end else if (pick < 60) begin
          c.kind = KIND_NEWLINE;
        end else if (pick < 70) begin
          c.kind = KIND_BACKSPACE;
        end else if (pick < 76) begin
          c.kind = KIND_CLEAR_LN;
          if ($urandom_range(99) < 90) c.row = ROW_W'($urandom_range(ROWS - 1));
        end else if (pick < 94) begin
          c.kind = KIND_READ;
          if ($urandom_range(99) < 85) begin
            c.col = COL_W'($urandom_range(COLUMNS - 1));
            c.row = ROW_W'($urandom_range(ROWS - 1));
          end
        end else if (pick < 97 || clears_left == 0) begin
          c.kind = KIND_NOP;
        end else begin
          // full sweeps are slow, so only a few per phase
          c.kind = KIND_CLEAR_SCR;
          clears_left--;
        end
        issue_cmd(c);
        sent++;
      end
    end
    wait_until_quiet();
  endtask

  // several colour settings, extremes first; one phase runs with no gaps
  task automatic test_colour_phases();
    logic [BYTE_W-1:0] colours [4];
    colours[0] = 8'h00;
    colours[1] = 8'hFF;
    colours[2] = BYTE_W'($urandom_range(255));
    colours[3] = RESET_COLOR;
    for (int i = 0; i < 4; i++) begin
      gaps_on = (i != 1);
      write_default_colour(colours[i]);
      run_console_traffic(PHASE_ITEMS);
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result checking: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    console_status_t want;
    if (rst_ni && done_o) begin
      if (status_reports_q.size() == 0) begin
        $error("status report with no command outstanding");
        error_count++;
      end else begin
        want = status_reports_q.pop_front();
        if (cursor_col_o !== want.col) begin
          $error("cursor_col mismatch: expected %0d, got %0d", want.col, cursor_col_o);
          error_count++;
        end
        if (cursor_row_o !== want.row) begin
          $error("cursor_row mismatch: expected %0d, got %0d", want.row, cursor_row_o);
          error_count++;
        end
        if (cell_data_o !== want.cell_data) begin
          $error("cell_data mismatch: expected %h, got %h", want.cell_data, cell_data_o);
          error_count++;
        end
        if (out_of_range_o !== want.oor) begin
          $error("out_of_range mismatch: expected %0d, got %0d", want.oor, out_of_range_o);
          error_count++;
        end
      end
    end
  end

  // watchdog, counts from time zero so the power-up fill is included
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KIND_NOP;
    char_code_i = '0;
    attr_i      = '0;
    col_i       = '0;
    line_num_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    gaps_on     = 1'b1;

    // shadow state matches the power-up fill
    shadow_colour = RESET_COLOR;
    for (int unsigned i = 0; i < CELLS; i++) shadow_cells[i] = {RESET_COLOR, BLANK_CHAR};
    shadow_col = '0;
    shadow_row = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // block sweeps the screen after reset; busy holds commands off until done
    test_reset_contents();
    test_directed_ops();
    test_colour_phases();

    wait_until_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && status_reports_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
